// File: hw/rtl/quintic_spline_kernel_eval_top_assert.svh
// Assertion macros for the quintic spline kernel evaluator.
// QSKE_ASSERT checks on every clock edge outside reset.
// QSKE_ASSERT_RST checks on every clock edge, reset included.
`ifndef QUINTIC_SPLINE_KERNEL_EVAL_TOP_ASSERT_SVH
`define QUINTIC_SPLINE_KERNEL_EVAL_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define QSKE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define QSKE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define QSKE_ASSERT(label, prop, msg)
`define QSKE_ASSERT_RST(label, prop, msg)
`endif
`endif

// File: hw/rtl/qske_pkg.sv
`default_nettype none

package qske_pkg;

    localparam int Q_W      = 18;
    localparam int SCALE_W  = 32;
    localparam int DIM_W    = 2;
    localparam int OUT_W    = 48;
    localparam int IDX_W    = 2;
    localparam int NUM_BR   = 3;
    localparam int NUM_STG  = 10;

    typedef logic [Q_W-1:0]            t_q;
    typedef logic [SCALE_W-1:0]        t_scale;
    typedef logic [DIM_W-1:0]          t_dim;
    typedef logic [IDX_W-1:0]          t_reg_idx;
    typedef logic signed [OUT_W-1:0]   t_out;

    // Register indexes of the configuration port.
    localparam t_reg_idx REG_SCALE_VALUE  = 2'd0;
    localparam t_reg_idx REG_SCALE_FIRST  = 2'd1;
    localparam t_reg_idx REG_SCALE_SECOND = 2'd2;
    localparam t_reg_idx REG_DIMENSION    = 2'd3;

    localparam t_scale SCALE_RESET = 32'd65536;
    localparam t_dim   DIM_RESET   = 2'd3;

    // 1.0 in Q2.16 and the upper edges 3.0, 2.0, 1.0 of the three spline terms.
    localparam t_q Q_ONE = 18'd65536;
    localparam t_q D_BOUND [NUM_BR] = '{18'd196608, 18'd131072, 18'd65536};

    localparam t_out OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam t_out OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

`default_nettype wire

// File: hw/rtl/qske_in_if.sv
`default_nettype none

interface qske_in_if;
    import qske_pkg::*;

    logic valid;
    logic ready;
    t_q   q;

    modport source (output valid, output q, input ready);
    modport sink   (input valid, input q, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/qske_out_if.sv
`default_nettype none

interface qske_out_if;
    import qske_pkg::*;

    logic valid;
    logic ready;
    t_out kernel_value;
    t_out first_deriv;
    t_out second_deriv;
    t_out laplacian;

    modport source (output valid, output kernel_value, output first_deriv,
                    output second_deriv, output laplacian, input ready);
    modport sink   (input valid, input kernel_value, input first_deriv,
                    input second_deriv, input laplacian, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/qske_cfg_if.sv
`default_nettype none

interface qske_cfg_if;
    import qske_pkg::*;

    logic     valid;
    logic     ready;
    t_reg_idx index;
    t_scale   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/quintic_spline_kernel_eval_top.sv
// Quintic spline SPH kernel evaluator. Each item on i_req carries a normalized
// distance q in unsigned Q2.16; the block answers with one item on o_rsp that
// holds the kernel value W, the first derivative dW/dq scaled by C/h, the
// second derivative scaled by C/h^2, and the Laplacian term
// second - (dimension - 1) * first, all signed Q16.16 in 48 bits. Distances
// of 3.0 and above give zero in all four fields. The block is a ten stage
// pipeline: it takes one item every clock cycle while the output register is
// empty or its result is taken. The whole pipeline moves as one; when the
// result in the output register is not taken, i_req.ready drops in the same
// cycle and every stage holds, so nothing is lost or repeated. The stage count
// is set by the chain of dependent multiplies: d^2, d^3, d^4 and d^5 each take
// a stage, and the final scaling by the Q16.16 factors is split into two
// partial products and a recombining add. Software writes C, C/h and C/h^2
// (unsigned Q16.16, reset 1.0) and the spatial dimension (reset 3) through
// i_cfg, which is always ready; writes should happen while no item is in
// flight, since the scale factors are sampled as an item passes stage eight.
`default_nettype none

`include "quintic_spline_kernel_eval_top_assert.svh"

module quintic_spline_kernel_eval_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qske_in_if.sink    i_req,
    qske_out_if.source o_rsp,
    qske_cfg_if.sink   i_cfg
);
    import qske_pkg::*;

    // Configuration registers.
    t_scale r_scale_value;
    t_scale r_scale_first;
    t_scale r_scale_second;
    t_dim   r_dim;

    // Valid bit of each stage; the top bit belongs to the output register.
    logic [NUM_STG-1:0] r_vld;
    logic               w_en;

    // Stage 1: distance to each term edge, zero where the term is dropped.
    logic [Q_W-1:0]   r_d1 [NUM_BR];
    logic [Q_W-1:0]   n_d1 [NUM_BR];
    // Stage 2: d^2 in Q.32.
    logic [35:0]      r_sq [NUM_BR];
    logic [35:0]      n_sq [NUM_BR];
    logic [Q_W-1:0]   r_d2 [NUM_BR];
    // Stage 3: d^3.
    logic [53:0]      w_p3 [NUM_BR];
    logic [36:0]      r_c3a [NUM_BR];
    logic [36:0]      n_c3 [NUM_BR];
    logic [Q_W-1:0]   r_d3 [NUM_BR];
    // Stage 4: d^4.
    logic [54:0]      w_p4 [NUM_BR];
    logic [38:0]      r_c4a [NUM_BR];
    logic [38:0]      n_c4 [NUM_BR];
    logic [36:0]      r_c3b [NUM_BR];
    logic [Q_W-1:0]   r_d4 [NUM_BR];
    // Stage 5: d^5.
    logic [55:0]      w_p5 [NUM_BR];
    logic [39:0]      r_c5 [NUM_BR];
    logic [39:0]      n_c5 [NUM_BR];
    logic [38:0]      r_c4b [NUM_BR];
    logic [36:0]      r_c3c [NUM_BR];
    // Stage 6: weighted sums over the three terms (weights 1, -6, 15).
    t_out             r_s5, r_s4, r_s3;
    t_out             n_s5, n_s4, n_s3;
    // Stage 7: value, first and second polynomial in signed Q.32.
    t_out             r_x [NUM_BR];
    t_out             n_x [NUM_BR];
    // Stage 8: high and low partial products with the scale factors.
    logic signed [32:0] w_sc [NUM_BR];
    logic signed [56:0] r_ph [NUM_BR];
    logic signed [56:0] r_pl [NUM_BR];
    logic signed [56:0] n_ph [NUM_BR];
    logic signed [56:0] n_pl [NUM_BR];
    // Stage 9: recombined product, floored to Q16.16.
    logic signed [80:0] w_full [NUM_BR];
    t_out             r_y [NUM_BR];
    t_out             n_y [NUM_BR];
    // Stage 10: output register with the Laplacian term.
    logic signed [49:0] w_lap;
    t_out             n_lap;
    t_out             r_o_val, r_o_first, r_o_second, r_o_lap;

    // Configuration port.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_value  <= SCALE_RESET;
            r_scale_first  <= SCALE_RESET;
            r_scale_second <= SCALE_RESET;
            r_dim          <= DIM_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SCALE_VALUE:  r_scale_value  <= i_cfg.data;
                REG_SCALE_FIRST:  r_scale_first  <= i_cfg.data;
                REG_SCALE_SECOND: r_scale_second <= i_cfg.data;
                REG_DIMENSION:    r_dim          <= i_cfg.data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is empty or drained.
    assign w_en        = !r_vld[NUM_STG-1] || o_rsp.ready;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NUM_STG-2:0], i_req.valid};
        end
    end

    assign w_sc[0] = $signed({1'b0, r_scale_value});
    assign w_sc[1] = $signed({1'b0, r_scale_first});
    assign w_sc[2] = $signed({1'b0, r_scale_second});

    always_comb begin
        for (int k = 0; k < NUM_BR; k++) begin
            n_d1[k] = (i_req.q < D_BOUND[k]) ? Q_W'(D_BOUND[k] - i_req.q) : '0;
            n_sq[k] = 36'(r_d1[k]) * 36'(r_d1[k]);
            // Each higher power is truncated back to Q.32.
            w_p3[k] = 54'(r_sq[k]) * 54'(r_d2[k]);
            n_c3[k] = w_p3[k][52:16];
            w_p4[k] = 55'(r_c3a[k]) * 55'(r_d3[k]);
            n_c4[k] = w_p4[k][54:16];
            w_p5[k] = 56'(r_c4a[k]) * 56'(r_d4[k]);
            n_c5[k] = w_p5[k][55:16];
        end

        n_s5 = t_out'(r_c5[0]) - 48'sd6 * t_out'(r_c5[1]) + 48'sd15 * t_out'(r_c5[2]);
        n_s4 = t_out'(r_c4b[0]) - 48'sd6 * t_out'(r_c4b[1]) + 48'sd15 * t_out'(r_c4b[2]);
        n_s3 = t_out'(r_c3c[0]) - 48'sd6 * t_out'(r_c3c[1]) + 48'sd15 * t_out'(r_c3c[2]);

        n_x[0] = r_s5;
        n_x[1] = t_out'(-(48'sd5 * r_s4));
        n_x[2] = t_out'(48'sd20 * r_s3);

        for (int j = 0; j < NUM_BR; j++) begin
            // Signed operand split into a signed upper half and an unsigned
            // lower half so each multiply stays near 24 by 32 bits.
            n_ph[j]   = 57'($signed(r_x[j][47:24])) * 57'(w_sc[j]);
            n_pl[j]   = 57'($signed({1'b0, r_x[j][23:0]})) * 57'(w_sc[j]);
            // Arithmetic shift right by 32 is the floor toward minus infinity.
            w_full[j] = (81'(r_ph[j]) <<< 24) + 81'(r_pl[j]);
            n_y[j]    = w_full[j][79:32];
        end

        // Dimension zero makes the factor minus one.
        case (r_dim)
            2'd0:    w_lap = 50'(r_y[2]) + 50'(r_y[1]);
            2'd1:    w_lap = 50'(r_y[2]);
            2'd2:    w_lap = 50'(r_y[2]) - 50'(r_y[1]);
            default: w_lap = 50'(r_y[2]) - (50'(r_y[1]) <<< 1);
        endcase

        if (w_lap > 50'(OUT_MAX)) begin
            n_lap = OUT_MAX;
        end else if (w_lap < 50'(OUT_MIN)) begin
            n_lap = OUT_MIN;
        end else begin
            n_lap = w_lap[OUT_W-1:0];
        end
    end

    // Datapath registers carry no reset; the valid bits qualify them.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NUM_BR; k++) begin
                r_d1[k]  <= n_d1[k];
                r_sq[k]  <= n_sq[k];
                r_d2[k]  <= r_d1[k];
                r_c3a[k] <= n_c3[k];
                r_d3[k]  <= r_d2[k];
                r_c4a[k] <= n_c4[k];
                r_c3b[k] <= r_c3a[k];
                r_d4[k]  <= r_d3[k];
                r_c5[k]  <= n_c5[k];
                r_c4b[k] <= r_c4a[k];
                r_c3c[k] <= r_c3b[k];
                r_x[k]   <= n_x[k];
                r_ph[k]  <= n_ph[k];
                r_pl[k]  <= n_pl[k];
                r_y[k]   <= n_y[k];
            end
            r_s5       <= n_s5;
            r_s4       <= n_s4;
            r_s3       <= n_s3;
            r_o_val    <= r_y[0];
            r_o_first  <= r_y[1];
            r_o_second <= r_y[2];
            r_o_lap    <= n_lap;
        end
    end

    assign o_rsp.valid        = r_vld[NUM_STG-1];
    assign o_rsp.kernel_value = r_o_val;
    assign o_rsp.first_deriv  = r_o_first;
    assign o_rsp.second_deriv = r_o_second;
    assign o_rsp.laplacian    = r_o_lap;

    `QSKE_ASSERT(a_stall_blocks_entry, (o_rsp.valid && !o_rsp.ready) |-> !i_req.ready, "input accepted while the output stalls")
    `QSKE_ASSERT(a_term_edges_ordered, (r_vld[0] && r_d1[1] != '0) |-> (r_d1[0] == Q_W'(r_d1[1] + Q_ONE)), "term distances out of step")
    `QSKE_ASSERT(a_result_from_pipe, $rose(o_rsp.valid) |-> $past(r_vld[NUM_STG-2]), "result appeared without an item in the last stage")
    `QSKE_ASSERT_RST(a_reset_empties, !$past(i_rst_n) |-> !o_rsp.valid, "result shown right after reset")

endmodule

`default_nettype wire
